// File: rtl/chm_pkg.sv
// shared types and constants of the chained hash key value map
package chm_pkg;

	localparam int KEY_W = 64;
	localparam int VAL_W = 64;
	localparam int MODE_W = 2;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FIND = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

	localparam logic [KEY_W-1:0] MIX_ADD = 64'h9e3779b97f4a7c15;
	localparam logic [KEY_W-1:0] MIX_MUL1 = 64'hbf58476d1ce4e5b9;
	localparam logic [KEY_W-1:0] MIX_MUL2 = 64'h94d049bb133111eb;

	// hash bits per residue digit of the bucket remainder
	localparam int MOD_DIGIT = 4;
	localparam int MOD_ROUNDS = KEY_W / MOD_DIGIT;

	typedef struct packed {
		logic load;
		logic hash_start;
		logic clr_step;
		logic head_latch;
		logic hit_latch;
		logic ent_adv;
		logic val_wr;
		logic set_full;
		logic push_new;
		logic del_a;
		logic del_b;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic hash_done;
		logic walk_end;
		logic key_match;
		logic pool_empty;
		logic prev_valid;
		logic out_free;
		logic hit;
		logic [MODE_W-1:0] mode;
	} sts_t;

endpackage

// File: rtl/chm_ram.sv
// generic single write port ram with registered read
module chm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/chm_hash.sv
// multicycle splitmix64 finalizer and bucket remainder unit
module chm_hash #(
	parameter int BUCKETS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [chm_pkg::KEY_W-1:0]  key,
	output logic                       done,
	output logic [$clog2(BUCKETS)-1:0] bucket
);

	import chm_pkg::*;

	localparam int BW = $clog2(BUCKETS);
	// width of the sum of all digit residues
	localparam int SW = BW + MOD_DIGIT + $clog2(MOD_ROUNDS);
	// reciprocal of BUCKETS, exact for every sum below 2**SW
	localparam int SH = SW + BW;
	localparam int RCW = SW + 2;
	localparam int PW = SW + RCW;
	localparam logic [RCW-1:0] RECIP =
		RCW'(((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));

	localparam logic [1:0] H_IDLE = 2'd0;
	localparam logic [1:0] H_MUL = 2'd1;
	localparam logic [1:0] H_XS = 2'd2;
	localparam logic [1:0] H_MOD = 2'd3;

	localparam logic [1:0] R_SUM = 2'd0;
	localparam logic [1:0] R_QUO = 2'd1;
	localparam logic [1:0] R_REM = 2'd2;

	logic [1:0] state_q;
	logic pass_q;
	logic [1:0] step_q;
	logic [1:0] cnt_q;
	logic [KEY_W-1:0] x_q;
	logic [KEY_W-1:0] acc_q;
	logic [SW-1:0] sum_q;
	logic [SW-1:0] quo_q;
	logic [BW-1:0] bucket_q;
	logic done_q;

	logic [KEY_W-1:0] k_add;
	logic [KEY_W-1:0] cmul;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] prod;
	logic [KEY_W-1:0] acc_n;
	logic [SW-1:0] dig_term [MOD_ROUNDS];
	logic [SW-1:0] sum_n;
	logic [PW-1:0] rq_prod;
	logic [SW-1:0] rem_n;

	assign k_add = key + MIX_ADD;
	assign cmul = pass_q ? MIX_MUL2 : MIX_MUL1;
	// low word of a 64x64 product from three 32x32 partial products
	assign mul_a = (step_q == 2'd2) ? x_q[63:32] : x_q[31:0];
	assign mul_b = (step_q == 2'd1) ? cmul[63:32] : cmul[31:0];
	assign prod = 64'(mul_a) * 64'(mul_b);
	assign acc_n = (step_q == 2'd0) ? prod : acc_q + {prod[31:0], 32'd0};

	// each hash digit weighted by its place value modulo BUCKETS
	for (genvar g = 0; g < MOD_ROUNDS; g++) begin : g_dig
		localparam logic [BW-1:0] RES =
			BW'((64'd1 << (MOD_DIGIT * g)) % 64'(BUCKETS));
		assign dig_term[g] = SW'(x_q[MOD_DIGIT*g +: MOD_DIGIT]) * SW'(RES);
	end

	always_comb begin
		sum_n = '0;
		for (int i = 0; i < MOD_ROUNDS; i++) begin
			sum_n = sum_n + dig_term[i];
		end
	end

	assign rq_prod = PW'(sum_q) * PW'(RECIP);
	assign rem_n = sum_q - quo_q * SW'(BUCKETS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			pass_q <= 1'b0;
			step_q <= 2'd0;
			cnt_q <= R_SUM;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				H_IDLE: begin
					if (start) begin
						pass_q <= 1'b0;
						step_q <= 2'd0;
						state_q <= H_MUL;
					end
				end
				H_MUL: begin
					if (step_q == 2'd2) begin
						step_q <= 2'd0;
						state_q <= H_XS;
					end else begin
						step_q <= step_q + 2'd1;
					end
				end
				H_XS: begin
					if (!pass_q) begin
						pass_q <= 1'b1;
						state_q <= H_MUL;
					end else begin
						cnt_q <= R_SUM;
						state_q <= H_MOD;
					end
				end
				H_MOD: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == R_REM) begin
						done_q <= 1'b1;
						state_q <= H_IDLE;
					end
				end
				default: state_q <= H_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == H_IDLE && start) begin
			x_q <= k_add ^ (k_add >> 30);
		end
		if (state_q == H_MUL) begin
			acc_q <= acc_n;
		end
		if (state_q == H_XS) begin
			x_q <= pass_q ? (acc_q ^ (acc_q >> 31)) : (acc_q ^ (acc_q >> 27));
		end
		if (state_q == H_MOD) begin
			if (cnt_q == R_SUM) begin
				sum_q <= sum_n;
			end
			if (cnt_q == R_QUO) begin
				quo_q <= SW'(rq_prod >> SH);
			end
			if (cnt_q == R_REM) begin
				bucket_q <= rem_n[BW-1:0];
			end
		end
	end

	assign done = done_q;
	assign bucket = bucket_q;

endmodule

// File: rtl/chm_ctrl.sv
// request sequencer of the hash map
module chm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  chm_pkg::sts_t sts,
	output chm_pkg::cmd_t cmd
);

	import chm_pkg::*;

	localparam logic [3:0] S_CLR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_HASH = 4'd2;
	localparam logic [3:0] S_HEADRD = 4'd3;
	localparam logic [3:0] S_HEADW = 4'd4;
	localparam logic [3:0] S_WALK = 4'd5;
	localparam logic [3:0] S_ENTW = 4'd6;
	localparam logic [3:0] S_ACT = 4'd7;
	localparam logic [3:0] S_POPW = 4'd8;
	localparam logic [3:0] S_DEL2 = 4'd9;
	localparam logic [3:0] S_DONE = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_n;

	always_comb begin
		cmd = '0;
		state_n = state_q;
		unique case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_n = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cmd.hash_start = 1'b1;
					state_n = S_HASH;
				end
			end
			S_HASH: begin
				if (sts.hash_done) begin
					state_n = (sts.mode == MODE_NONE) ? S_DONE : S_HEADRD;
				end
			end
			S_HEADRD: state_n = S_HEADW;
			S_HEADW: begin
				cmd.head_latch = 1'b1;
				state_n = S_WALK;
			end
			S_WALK: state_n = sts.walk_end ? S_ACT : S_ENTW;
			S_ENTW: begin
				if (sts.key_match) begin
					cmd.hit_latch = 1'b1;
					state_n = S_ACT;
				end else begin
					cmd.ent_adv = 1'b1;
					state_n = S_WALK;
				end
			end
			S_ACT: begin
				state_n = S_DONE;
				case (sts.mode)
					MODE_INSERT: begin
						if (sts.hit) begin
							cmd.val_wr = 1'b1;
						end else if (sts.pool_empty) begin
							cmd.set_full = 1'b1;
						end else begin
							state_n = S_POPW;
						end
					end
					MODE_DELETE: begin
						if (sts.hit) begin
							cmd.del_a = 1'b1;
							if (sts.prev_valid) begin
								state_n = S_DEL2;
							end
						end
					end
					default: state_n = S_DONE;
				endcase
			end
			S_POPW: begin
				cmd.push_new = 1'b1;
				state_n = S_DONE;
			end
			S_DEL2: begin
				cmd.del_b = 1'b1;
				state_n = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_n;
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

// File: rtl/chm_dp.sv
// datapath of the hash map: hash unit, chain memories, free stack, result register
module chm_dp #(
	parameter int BUCKETS = 16,
	parameter int ENTRIES = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  chm_pkg::cmd_t                 cmd,
	output chm_pkg::sts_t                 sts,
	input  logic [chm_pkg::MODE_W-1:0]    mode,
	input  logic [chm_pkg::KEY_W-1:0]     key,
	input  logic [chm_pkg::VAL_W-1:0]     value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic [chm_pkg::VAL_W-1:0]     value_out,
	output logic [$clog2(ENTRIES+1)-1:0]  entry_count,
	output logic                          table_full
);

	import chm_pkg::*;

	localparam int BW = $clog2(BUCKETS);
	localparam int IW = $clog2(ENTRIES);
	localparam int LW = $clog2(ENTRIES + 1);
	localparam int CLRN = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
	localparam int CLW = $clog2(CLRN);
	localparam logic [LW-1:0] NIL = LW'(ENTRIES);

	logic [MODE_W-1:0] mode_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;
	logic [VAL_W-1:0] hit_val_q;
	logic hit_q;
	logic full_q;
	logic [LW-1:0] cur_q;
	logic [LW-1:0] prev_q;
	logic [LW-1:0] next_q;
	logic [LW-1:0] head_q;
	logic [LW-1:0] steps_q;
	logic [LW-1:0] top_q;
	logic [LW-1:0] count_q;
	logic [CLW-1:0] clr_q;

	logic out_valid_q;
	logic found_q;
	logic [VAL_W-1:0] vout_q;
	logic [LW-1:0] cnt_out_q;
	logic full_out_q;

	logic hash_done;
	logic [BW-1:0] bucket;

	logic [KEY_W-1:0] key_rd;
	logic [VAL_W-1:0] val_rd;
	logic [LW-1:0] link_rd;
	logic [LW-1:0] head_rd;
	logic [IW-1:0] fs_rd;
	logic [LW-1:0] top_m1;

	logic key_we;
	logic val_we;
	logic [IW-1:0] val_wa;
	logic link_we;
	logic [IW-1:0] link_wa;
	logic [LW-1:0] link_wd;
	logic head_we;
	logic [BW-1:0] head_wa;
	logic [LW-1:0] head_wd;
	logic fs_we;
	logic [IW-1:0] fs_wa;
	logic [IW-1:0] fs_wd;
	logic clr_head;
	logic clr_fs;
	logic top_room;

	chm_hash #(.BUCKETS(BUCKETS)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.hash_start),
		.key    (key),
		.done   (hash_done),
		.bucket (bucket)
	);

	assign top_m1 = top_q - LW'(1);
	assign top_room = (top_q < NIL);
	assign clr_head = cmd.clr_step && ({1'b0, clr_q} < (CLW+1)'(BUCKETS));
	assign clr_fs = cmd.clr_step && ({1'b0, clr_q} < (CLW+1)'(ENTRIES));

	assign key_we = cmd.push_new;
	assign val_we = cmd.push_new || cmd.val_wr;
	assign val_wa = cmd.push_new ? fs_rd : cur_q[IW-1:0];

	always_comb begin
		link_we = 1'b1;
		link_wa = fs_rd;
		link_wd = head_q;
		if (cmd.del_a) begin
			link_wa = cur_q[IW-1:0];
			link_wd = NIL;
		end else if (cmd.del_b) begin
			link_wa = prev_q[IW-1:0];
			link_wd = next_q;
		end else if (!cmd.push_new) begin
			link_we = 1'b0;
		end
	end

	always_comb begin
		head_we = 1'b1;
		head_wa = bucket;
		head_wd = LW'(fs_rd);
		if (clr_head) begin
			head_wa = clr_q[BW-1:0];
			head_wd = NIL;
		end else if (cmd.del_a && !(prev_q < NIL)) begin
			head_wd = next_q;
		end else if (!cmd.push_new) begin
			head_we = 1'b0;
		end
	end

	always_comb begin
		fs_we = clr_fs || (cmd.del_a && top_room);
		fs_wa = clr_fs ? clr_q[IW-1:0] : top_q[IW-1:0];
		fs_wd = clr_fs ? (IW'(ENTRIES - 1) - clr_q[IW-1:0]) : cur_q[IW-1:0];
	end

	chm_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_keys (
		.clk (clk), .we (key_we), .waddr (fs_rd), .wdata (key_q),
		.raddr (cur_q[IW-1:0]), .rdata (key_rd)
	);

	chm_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_vals (
		.clk (clk), .we (val_we), .waddr (val_wa), .wdata (value_q),
		.raddr (cur_q[IW-1:0]), .rdata (val_rd)
	);

	chm_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_links (
		.clk (clk), .we (link_we), .waddr (link_wa), .wdata (link_wd),
		.raddr (cur_q[IW-1:0]), .rdata (link_rd)
	);

	chm_ram #(.WIDTH(LW), .DEPTH(BUCKETS)) u_heads (
		.clk (clk), .we (head_we), .waddr (head_wa), .wdata (head_wd),
		.raddr (bucket), .rdata (head_rd)
	);

	chm_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_free (
		.clk (clk), .we (fs_we), .waddr (fs_wa), .wdata (fs_wd),
		.raddr (top_m1[IW-1:0]), .rdata (fs_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			top_q <= NIL;
			count_q <= '0;
			out_valid_q <= 1'b0;
			hit_q <= 1'b0;
			full_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + CLW'(1);
			end
			if (cmd.load) begin
				hit_q <= 1'b0;
				full_q <= 1'b0;
			end
			if (cmd.hit_latch) begin
				hit_q <= 1'b1;
			end
			if (cmd.set_full) begin
				full_q <= 1'b1;
			end
			if (cmd.push_new) begin
				top_q <= top_m1;
				count_q <= count_q + LW'(1);
			end
			if (cmd.del_a) begin
				if (top_room) begin
					top_q <= top_q + LW'(1);
				end
				if (count_q != '0) begin
					count_q <= count_q - LW'(1);
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			key_q <= key;
			value_q <= value;
		end
		if (cmd.head_latch) begin
			cur_q <= head_rd;
			head_q <= head_rd;
			prev_q <= NIL;
			steps_q <= '0;
		end
		if (cmd.ent_adv) begin
			prev_q <= cur_q;
			cur_q <= link_rd;
			steps_q <= steps_q + LW'(1);
		end
		if (cmd.hit_latch) begin
			hit_val_q <= val_rd;
			next_q <= link_rd;
		end
		if (cmd.out_load) begin
			found_q <= hit_q;
			vout_q <= (hit_q && (mode_q == MODE_FIND || mode_q == MODE_DELETE))
				? hit_val_q : '0;
			cnt_out_q <= count_q;
			full_out_q <= full_q;
		end
	end

	assign sts.clr_last = (clr_q == CLW'(CLRN - 1));
	assign sts.hash_done = hash_done;
	assign sts.walk_end = !(cur_q < NIL) || !(steps_q < NIL);
	assign sts.key_match = (key_rd == key_q);
	assign sts.pool_empty = (top_q == '0);
	assign sts.prev_valid = (prev_q < NIL);
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.hit = hit_q;
	assign sts.mode = mode_q;

	assign out_valid = out_valid_q;
	assign found = found_q;
	assign value_out = vout_q;
	assign entry_count = cnt_out_q;
	assign table_full = full_out_q;

`ifndef SYNTHESIS
	a_pool_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(LW+1)'(count_q) + (LW+1)'(top_q) == (LW+1)'(ENTRIES))
		else $error("held count and free stack depth disagree");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_new |-> top_q != '0)
		else $error("allocation from an empty free stack");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before transfer");

	a_full_miss: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load && full_q |-> !hit_q && mode_q == MODE_INSERT)
		else $error("full flag on a request other than an insert miss");
`endif

endmodule

// File: rtl/chained_hash_key_value_map.sv
// top level of the chained hash key value map engine
// keyed 64-bit map: each request transfer carries mode (insert, find, delete),
// key and value; each request gives exactly one result transfer with found,
// value_out, entry_count and table_full.
// both channels are valid/ready; a request transfers when in_valid and
// in_ready are high at a rising edge, a result when out_valid and out_ready are.
// after arst_n releases, a clearing pass over max(BUCKETS, ENTRIES) addresses
// empties the bucket heads and fills the free stack; in_ready stays low then.
// request steps: the hash unit runs two 64-bit multiplies of three
// 32x32 partial products each on one shared multiplier, two xor-shift steps,
// then residue sum, reciprocal quotient and subtract for the bucket index;
// the chain walk then visits each entry in a walk and a compare state on the
// registered-read memories; the unused mode skips the walk.
// one request is handled at a time; in_ready rises as its result is loaded.
// a finished result waits in the output register while the receiver stalls;
// the next request is accepted and worked on meanwhile, and only its own
// result load waits for the register to free up.
module chained_hash_key_value_map #(
	parameter int BUCKETS = 16,
	parameter int ENTRIES = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [chm_pkg::MODE_W-1:0]    mode,
	input  logic [chm_pkg::KEY_W-1:0]     key,
	input  logic [chm_pkg::VAL_W-1:0]     value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found,
	output logic [chm_pkg::VAL_W-1:0]     value_out,
	output logic [$clog2(ENTRIES+1)-1:0]  entry_count,
	output logic                          table_full
);

	import chm_pkg::*;

	// commands from the sequencer, status back from the datapath
	cmd_t cmd;
	sts_t sts;

	chm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// request registers, hash unit, chain memories and result register
	chm_dp #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.mode        (mode),
		.key         (key),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.found       (found),
		.value_out   (value_out),
		.entry_count (entry_count),
		.table_full  (table_full)
	);

endmodule
